>>> rtl/column_label_occupancy_counter_top_defines.svh
// Assertion macros for the column label occupancy counter.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef COLUMN_LABEL_OCCUPANCY_COUNTER_TOP_DEFINES_SVH
`define COLUMN_LABEL_OCCUPANCY_COUNTER_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define CLO_ASSERT(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// pre at one edge implies post at the next
`define CLO_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> rtl/clo_pkg.sv
// Shared types and constants for the column label occupancy counter.
// No dependencies.
package clo_pkg;

	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLUMNS = 256;

	localparam int ROW_AW = $clog2(MAX_ROWS);
	localparam int CNT_W  = ROW_AW + 1;
	localparam int COL_AW = $clog2(MAX_COLUMNS);
	localparam int COL_W  = COL_AW + 1;
	localparam int POS_W  = 2 * ROW_AW;
	localparam int DIV_CW = $clog2(POS_W) + 1;

	localparam int CFG_W     = 9;
	localparam int CFG_AW    = 2;
	localparam int LABEL_W   = 8;
	localparam int COUNT_W   = 9;
	localparam int INDEX_W   = 8;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_AW-1:0] REG_NUM_COLUMNS = 2'd0;
	localparam logic [CFG_AW-1:0] REG_NUM_ROWS    = 2'd1;
	localparam logic [CFG_AW-1:0] REG_MATCH_MASK  = 2'd2;

	localparam logic [CFG_W-1:0]   RST_NUM_COLUMNS = 9'd160;
	localparam logic [CFG_W-1:0]   RST_NUM_ROWS    = 9'd120;
	localparam logic [LABEL_W-1:0] RST_MATCH_MASK  = 8'd25;

	typedef struct packed {
		logic take;
		logic div_start;
		logic div_step;
		logic mag;
		logic chk;
		logic rc_step;
		logic load_out;
	} clo_cmd_t;

	typedef struct packed {
		logic col_end;
		logic cnt_zero;
		logic div_last;
		logic recal_need;
		logic rc_done;
		logic out_free;
	} clo_status_t;

	function automatic logic [CNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0)
			r = CNT_W'(1);
		else if (32'(v) > MAX_ROWS)
			r = CNT_W'(MAX_ROWS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

	function automatic logic [COL_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
		logic [COL_W-1:0] r;
		if (v == '0)
			r = COL_W'(1);
		else if (32'(v) > MAX_COLUMNS)
			r = COL_W'(MAX_COLUMNS);
		else
			r = COL_W'(v);
		return r;
	endfunction

endpackage

>>> rtl/clo_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clo_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/clo_datapath.sv
// Datapath: config registers, column accumulators, match bitmap RAM,
// restoring divider, recount and output register. Uses clo_pkg, clo_ram.
module clo_datapath
	import clo_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	input  logic [LABEL_W-1:0]    s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast,
	input  clo_cmd_t              cmd,
	output clo_status_t           st
);

	logic [CFG_W-1:0]   num_columns_q;
	logic [CFG_W-1:0]   num_rows_q;
	logic [LABEL_W-1:0] match_mask_q;

	logic [ROW_AW-1:0] row_q;
	logic [CNT_W-1:0]  hit_q;
	logic [POS_W-1:0]  pos_q;
	logic [COL_AW-1:0] col_q;
	logic [CNT_W-1:0]  rows_l_q;
	logic              last_l_q;

	logic [CNT_W-1:0]  rem_q;
	logic [POS_W-1:0]  dvd_q;
	logic [DIV_CW-1:0] div_cnt_q;

	logic [CNT_W:0]    mag_q;
	logic              recal_q;
	logic [CNT_W-1:0]  rc_j_q;
	logic              rc_pend_q;
	logic [CNT_W-1:0]  acc_q;

	logic              out_valid_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [INDEX_W-1:0] out_index_q;
	logic              out_recal_q;
	logic              out_last_q;

	logic [CNT_W-1:0]  rows_c;
	logic [COL_W-1:0]  cols_c;
	logic              accept;
	logic              hit;
	logic              row_end;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W+1:0]  diff;
	logic [CNT_W+4:0]  mag10;
	logic              rc_more;
	logic              rd_bit;

	assign rows_c  = clamp_rows(num_rows_q);
	assign cols_c  = clamp_cols(num_columns_q);
	assign accept  = cmd.take && s_tvalid;
	assign hit     = |(s_tdata & match_mask_q);
	assign row_end = (CNT_W'(row_q) + CNT_W'(1)) >= rows_c;

	assign trial = {rem_q, dvd_q[POS_W-1]};
	assign ge    = trial >= {1'b0, hit_q};

	// aveval - aveidx, quotient sits in the low bits of dvd_q after the divide
	assign diff = (CNT_W+2)'(rows_l_q) - (CNT_W+2)'(hit_q >> 1)
		- (CNT_W+2)'(dvd_q[CNT_W-1:0]);
	assign mag10 = (CNT_W+5)'({mag_q, 3'b000}) + (CNT_W+5)'({mag_q, 1'b0});

	assign rc_more = rc_j_q < rows_l_q;

	clo_ram #(
		.WIDTH(1),
		.DEPTH(MAX_ROWS)
	) u_bits (
		.clk    (clk),
		.wr_en  (accept),
		.wr_addr(row_q),
		.wr_data(hit),
		.rd_en  (cmd.rc_step && rc_more),
		.rd_addr(rc_j_q[ROW_AW-1:0]),
		.rd_data(rd_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_columns_q <= RST_NUM_COLUMNS;
			num_rows_q    <= RST_NUM_ROWS;
			match_mask_q  <= RST_MATCH_MASK;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_NUM_COLUMNS: num_columns_q <= cfg_wdata;
				REG_NUM_ROWS:    num_rows_q    <= cfg_wdata;
				REG_MATCH_MASK:  match_mask_q  <= cfg_wdata[LABEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			hit_q       <= '0;
			pos_q       <= '0;
			col_q       <= '0;
			div_cnt_q   <= '0;
			recal_q     <= 1'b0;
			rc_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (hit) begin
					hit_q <= hit_q + CNT_W'(1);
					pos_q <= pos_q + POS_W'(row_q) + POS_W'(1);
				end
				if (row_end)
					row_q <= '0;
				else
					row_q <= row_q + ROW_AW'(1);
			end
			if (cmd.div_start)
				div_cnt_q <= DIV_CW'(POS_W);
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q - DIV_CW'(1);
			if (cmd.chk)
				recal_q <= st.recal_need;
			if (cmd.rc_step)
				rc_pend_q <= rc_more;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
				recal_q     <= 1'b0;
				hit_q       <= '0;
				pos_q       <= '0;
				col_q       <= last_l_q ? '0 : col_q + COL_AW'(1);
			end else if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && row_end) begin
			rows_l_q <= rows_c;
			last_l_q <= (COL_W'(col_q) + COL_W'(1)) >= cols_c;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			dvd_q <= pos_q;
		end else if (cmd.div_step) begin
			rem_q <= ge ? CNT_W'(trial - {1'b0, hit_q}) : trial[CNT_W-1:0];
			dvd_q <= {dvd_q[POS_W-2:0], ge};
		end
		if (cmd.mag) begin
			mag_q  <= diff[CNT_W+1] ? (CNT_W+1)'(-diff) : diff[CNT_W:0];
			rc_j_q <= dvd_q[CNT_W-1:0];
			acc_q  <= '0;
		end
		if (cmd.rc_step) begin
			if (rc_more)
				rc_j_q <= rc_j_q + CNT_W'(1);
			if (rc_pend_q)
				acc_q <= acc_q + CNT_W'(rd_bit);
		end
		if (cmd.load_out) begin
			out_count_q <= COUNT_W'(recal_q ? acc_q : hit_q);
			out_index_q <= INDEX_W'(col_q);
			out_recal_q <= recal_q;
			out_last_q  <= last_l_q;
		end
	end

	always_comb begin
		st.col_end    = accept && row_end;
		st.cnt_zero   = hit_q == '0;
		st.div_last   = div_cnt_q == DIV_CW'(1);
		st.recal_need = mag10 > (CNT_W+5)'(rows_l_q);
		st.rc_done    = !rc_more && !rc_pend_q;
		st.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_DATA_W'({out_recal_q, out_index_q, out_count_q});

endmodule

>>> rtl/clo_ctrl.sv
// Controller state machine: sequences pixel intake, divide, check,
// recount and result hand-off. Uses clo_pkg.
module clo_ctrl
	import clo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  clo_status_t st,
	output clo_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_ACCEPT,
		S_START,
		S_DIV,
		S_MAG,
		S_CMP,
		S_RECOUNT,
		S_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACCEPT;
		end else begin
			case (state_q)
				S_ACCEPT:  if (st.col_end) state_q <= S_START;
				S_START:   state_q <= st.cnt_zero ? S_OUT : S_DIV;
				S_DIV:     if (st.div_last) state_q <= S_MAG;
				S_MAG:     state_q <= S_CMP;
				S_CMP:     state_q <= st.recal_need ? S_RECOUNT : S_OUT;
				S_RECOUNT: if (st.rc_done) state_q <= S_OUT;
				S_OUT:     if (st.out_free) state_q <= S_ACCEPT;
				default:   state_q <= S_ACCEPT;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_ACCEPT:  cmd.take      = 1'b1;
			S_START:   cmd.div_start = !st.cnt_zero;
			S_DIV:     cmd.div_step  = 1'b1;
			S_MAG:     cmd.mag       = 1'b1;
			S_CMP:     cmd.chk       = 1'b1;
			S_RECOUNT: cmd.rc_step   = 1'b1;
			S_OUT:     cmd.load_out  = st.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

>>> rtl/column_label_occupancy_counter_top.sv
// Column label occupancy counter, top level.
// Uses clo_pkg, clo_ctrl, clo_datapath and the assertion macro header.
//
// Usage:
// Label pixels enter on the s_ stream, one column at a time, top to bottom
// (s_tdata[7:0] = label). One result per column leaves on the m_ stream.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata
// while the block is idle: 0 num_columns, 1 num_rows, 2 match_mask.
// Throughput: one pixel per cycle inside a column. After the last pixel of a
// column intake pauses: an empty column skips straight to the output load,
// any other runs a 16-step restoring divide of the row sum by the count, the
// distance check and the output load, plus a recount when one is needed,
// one row of the bitmap RAM read per cycle. The result is loaded in the
// last cycle of the pause and is valid when intake resumes.
// The output register holds one result; intake resumes while it waits, and
// the next column end stalls only if that result has still not been taken.
// Reset clears counters and loads default register values; the bitmap RAM
// is not cleared, since each column rewrites every row it later reads.
`include "column_label_occupancy_counter_top_defines.svh"

module column_label_occupancy_counter_top
	import clo_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_AW-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [LABEL_W-1:0]    s_tdata,    // [7:0] label
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,    // [8:0] column_count, [16:9] column_index,
	                                          // [17] recalibrated, zero above
	output logic                  m_tlast     // last_column
);

	clo_cmd_t    cmd;
	clo_status_t st;

	clo_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	clo_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.st       (st)
	);

	assign s_tready = cmd.take;

	`CLO_ASSERT(a_no_overwrite, !(cmd.load_out && m_tvalid && !m_tready), "result overwritten")
	`CLO_ASSERT(a_one_cmd, $onehot0(cmd), "commands overlap")
	`CLO_ASSERT_NEXT(a_load_valid, cmd.load_out, m_tvalid, "loaded result not presented")
	`CLO_ASSERT_NEXT(a_end_stops_intake, st.col_end, !s_tready, "intake continued past column end")

endmodule

>>> tb/sv/tb_column_label_occupancy_counter_top.sv
// Testbench for column_label_occupancy_counter_top: drives label pixels with random
// idling on both streams and checks every column result against a model.
// Depends on clo_pkg and the top level RTL only.
module tb_column_label_occupancy_counter_top;
	timeunit 1ns;
	timeprecision 1ps;
	import clo_pkg::*;

	localparam logic [CFG_AW-1:0] REG_SPARE = 2'd3;
	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 320;
	localparam int HOLD_CYCLES   = 400;
	localparam int WARMUP_ITEMS  = 40;
	localparam int RANDOM_ITEMS  = 620;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [INDEX_W-1:0] index;
		logic               recal;
		logic               last;
	} column_result_t;

	typedef enum int {COL_DENSITY, COL_RUN, COL_SINGLE, COL_NOISE, COL_TAIL} column_style_e;

	class occupancy_scoreboard;
		logic [CFG_W-1:0]   cols_reg = RST_NUM_COLUMNS;
		logic [CFG_W-1:0]   rows_reg = RST_NUM_ROWS;
		logic [LABEL_W-1:0] mask_reg = RST_MATCH_MASK;
		bit                 occ_rows [MAX_ROWS];
		int unsigned        row_ctr = 0;
		int unsigned        hit_ctr = 0;
		int unsigned        pos_sum = 0;
		int unsigned        col_ctr = 0;
		column_result_t     results_due [$];
		int unsigned        errors = 0;
		int unsigned        columns = 0;
		int unsigned        recounts = 0;
		int unsigned        empties = 0;

		function int unsigned eff_size(logic [CFG_W-1:0] v, int unsigned hi);
			if (v == '0)
				return 1;
			if (v > hi)
				return hi;
			return int'(v);
		endfunction

		function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] value);
			case (addr)
			REG_NUM_COLUMNS: cols_reg = value;
			REG_NUM_ROWS:    rows_reg = value;
			REG_MATCH_MASK:  mask_reg = value[LABEL_W-1:0];
			default: ;
			endcase
		endfunction

		// one accepted pixel; queues a column result when the column closes
		function void note_pixel(logic [LABEL_W-1:0] lbl);
			int unsigned rows_e, cols_e, row, cnt, ave_idx, j;
			int ave_val, diff, mag;
			bit hit;
			column_result_t r;
			rows_e = eff_size(rows_reg, MAX_ROWS);
			cols_e = eff_size(cols_reg, MAX_COLUMNS);
			row = row_ctr;
			hit = (lbl & mask_reg) != '0;
			occ_rows[row] = hit;
			if (hit) begin
				hit_ctr++;
				pos_sum += row + 1;
			end
			if (row + 1 < rows_e) begin
				row_ctr = row + 1;
				return;
			end
			cnt = hit_ctr;
			r.recal = 1'b0;
			if (cnt != 0) begin
				ave_val = int'(rows_e) - int'(cnt / 2);
				ave_idx = pos_sum / cnt;
				diff = ave_val - int'(ave_idx);
				mag = (diff < 0) ? -diff : diff;
				if (10 * mag > int'(rows_e)) begin
					r.recal = 1'b1;
					cnt = 0;
					for (j = ave_idx; j < rows_e; j++)
						cnt += occ_rows[j];
				end
			end else begin
				empties++;
			end
			if (r.recal)
				recounts++;
			r.last = (col_ctr + 1 >= cols_e);
			r.count = COUNT_W'(cnt);
			r.index = INDEX_W'(col_ctr);
			results_due.push_back(r);
			row_ctr = 0;
			hit_ctr = 0;
			pos_sum = 0;
			col_ctr = r.last ? 0 : col_ctr + 1;
		endfunction

		function void flag(string field, int unsigned want, int unsigned got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void check_column(logic [OUT_DATA_W-1:0] data, logic last);
			column_result_t want;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0t: result with none due, expected nothing, actual data=%h last=%b",
					$time, data, last);
				return;
			end
			want = results_due.pop_front();
			columns++;
			if (data[COUNT_W-1:0] != want.count)
				flag("column_count", want.count, data[COUNT_W-1:0]);
			if (data[COUNT_W +: INDEX_W] != want.index)
				flag("column_index", want.index, data[COUNT_W +: INDEX_W]);
			if (data[COUNT_W+INDEX_W] != want.recal)
				flag("recalibrated", want.recal, data[COUNT_W+INDEX_W]);
			if (data[OUT_DATA_W-1:COUNT_W+INDEX_W+1] != '0)
				flag("tdata pad", 0, data[OUT_DATA_W-1:COUNT_W+INDEX_W+1]);
			if (last !== want.last)
				flag("last_column", want.last, last);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_AW-1:0]     cfg_addr = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [LABEL_W-1:0]    s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	occupancy_scoreboard sb = new();
	bit          tx_quiet = 1'b0;
	bit          rx_quiet = 1'b0;
	bit          tx_pressure = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned tx_count = 0;
	int unsigned rx_count = 0;
	int unsigned cfg_writes = 0;
	int unsigned phases = 0;

	column_label_occupancy_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic write_reg(input logic [CFG_AW-1:0] addr, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= CFG_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(addr, CFG_W'(value));
		cfg_writes++;
	endtask

	task automatic send_label(input logic [LABEL_W-1:0] lbl);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= lbl;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pixel(lbl);
		tx_count++;
		if (!tx_pressure && tx_count % 32 == 0)
			tx_quiet = ($urandom_range(0, 3) == 0);
	endtask

	// drop valid, let every due result out, then let the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [LABEL_W-1:0] pick_label(input bit hit);
		logic [LABEL_W-1:0] v;
		int b;
		v = LABEL_W'($urandom);
		if (!hit)
			return v & ~sb.mask_reg;
		if (sb.mask_reg == '0)
			return v;
		b = $urandom_range(0, LABEL_W - 1);
		while (!sb.mask_reg[b])
			b = (b + 1) % LABEL_W;
		v[b] = 1'b1;
		return v;
	endfunction

	function automatic int unsigned column_left();
		int unsigned rows_e;
		rows_e = sb.eff_size(sb.rows_reg, MAX_ROWS);
		return (sb.row_ctr + 1 >= rows_e) ? 1 : rows_e - sb.row_ctr;
	endfunction

	task automatic send_column(input int unsigned n);
		column_style_e style;
		int pct, lo, hi, r;
		style = column_style_e'($urandom_range(0, 4));
		pct = $urandom_range(0, 100);
		lo = $urandom_range(0, n - 1);
		hi = $urandom_range(lo, n - 1);
		for (r = 0; r < n; r++) begin
			case (style)
			COL_DENSITY: send_label(pick_label($urandom_range(0, 99) < pct));
			COL_RUN:     send_label(pick_label(r >= lo && r <= hi));
			COL_SINGLE:  send_label(pick_label(r == lo));
			COL_NOISE:   send_label(LABEL_W'($urandom));
			default:     send_label(pick_label(r >= lo));
			endcase
		end
	endtask

	task automatic random_phase();
		int unsigned pick, rows_v, cols_v, ncols, k, rows_e;
		wait_drained();
		pick = $urandom_range(0, 19);
		if (pick < 13)
			rows_v = $urandom_range(1, 12);
		else if (pick < 18)
			rows_v = $urandom_range(13, 40);
		else
			rows_v = 0;
		cols_v = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 12);
		if ($urandom_range(0, 2) != 0 || sb.eff_size(sb.rows_reg, MAX_ROWS) > 40)
			write_reg(REG_NUM_ROWS, rows_v);
		if ($urandom_range(0, 2) != 0)
			write_reg(REG_NUM_COLUMNS, cols_v);
		case ($urandom_range(0, 7))
		0: write_reg(REG_MATCH_MASK, 0);
		1: write_reg(REG_MATCH_MASK, 8'hFF);
		2, 3: ;
		default: write_reg(REG_MATCH_MASK, $urandom_range(0, 255));
		endcase
		rows_e = sb.eff_size(sb.rows_reg, MAX_ROWS);
		ncols = (rows_e > 12) ? $urandom_range(1, 3) : $urandom_range(1, 12);
		repeat (ncols) send_column(column_left());
		// sometimes stop mid-column so the next settings land inside it
		if (rows_e > 1 && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(1, rows_e - 1);
			repeat (k) send_label(pick_label($urandom_range(0, 1)));
		end
		phases++;
	endtask

	initial begin : result_sink
		int gap;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			gap = hold_req ? HOLD_CYCLES : (rx_quiet ? 0 : $urandom_range(0, 5));
			hold_req = 1'b0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			sb.check_column(m_tdata, m_tlast);
			rx_count++;
			if (rx_count % 16 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout with %0d results still due", $time, sb.results_due.size());
		$display("[column_label_occupancy_counter_top] ERROR");
		$finish;
	end

	initial begin : stimulus
		logic [LABEL_W-1:0] pix [$];
		int unsigned directed_items;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// two-column frames of four rows: plain count, empty column, recounts
		write_reg(REG_NUM_COLUMNS, 2);
		write_reg(REG_NUM_ROWS, 4);
		write_reg(REG_MATCH_MASK, 8'h19);
		write_reg(REG_SPARE, 9'h1FF);
		pix = '{8'h00, 8'hFF, 8'h01, 8'h08, 8'hE6, 8'hE6, 8'hE6, 8'hE6,
			8'h10, 8'h00, 8'h00, 8'h00, 8'h08, 8'h01, 8'h00, 8'hFF};
		foreach (pix[i])
			send_label(pix[i]);

		// rows shrink mid-column; recount would start past the column end
		wait_drained();
		write_reg(REG_MATCH_MASK, 8'hFF);
		write_reg(REG_NUM_ROWS, 8);
		write_reg(REG_NUM_COLUMNS, 1);
		pix = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80};
		foreach (pix[i])
			send_label(pix[i]);
		wait_drained();
		write_reg(REG_NUM_ROWS, 2);
		send_label(8'h00);

		// zero sizes act as one
		wait_drained();
		write_reg(REG_NUM_ROWS, 0);
		write_reg(REG_NUM_COLUMNS, 0);
		write_reg(REG_MATCH_MASK, 0);
		send_label(8'hFF);
		wait_drained();
		write_reg(REG_MATCH_MASK, 8'h80);
		send_label(8'h80);
		directed_items = tx_count;

		while (tx_count < directed_items + WARMUP_ITEMS)
			random_phase();

		// widest frame, one pixel per column
		wait_drained();
		write_reg(REG_NUM_ROWS, 0);
		write_reg(REG_NUM_COLUMNS, 511);
		write_reg(REG_MATCH_MASK, $urandom_range(1, 254));
		repeat (MAX_COLUMNS) send_column(column_left());

		// tallest column
		wait_drained();
		write_reg(REG_NUM_ROWS, 511);
		write_reg(REG_NUM_COLUMNS, 3);
		send_column(column_left());

		// output held off while the sender keeps pushing
		wait_drained();
		write_reg(REG_NUM_ROWS, 2);
		write_reg(REG_NUM_COLUMNS, 5);
		tx_pressure = 1'b1;
		tx_quiet = 1'b1;
		hold_req = 1'b1;
		repeat (25) send_column(column_left());
		tx_pressure = 1'b0;

		while (tx_count < directed_items + RANDOM_ITEMS)
			random_phase();
		wait_drained();

		$display("Covered %0d pixel requests and %0d column results over %0d register writes.",
			tx_count, sb.columns, cfg_writes);
		$display("%0d columns were recounted, %0d were empty, %0d random phases ran.",
			sb.recounts, sb.empties, phases);
		if (sb.errors == 0 && sb.results_due.size() == 0) begin
			$display("[column_label_occupancy_counter_top] OK");
		end else begin
			$display("[column_label_occupancy_counter_top] ERROR");
		end
		$finish;
	end

endmodule
